// File: rtl/channel_fragment_reassembler_core_macros.svh
// Assertion macros shared by the checker module.
`ifndef CHANNEL_FRAGMENT_REASSEMBLER_CORE_MACROS_SVH
`define CHANNEL_FRAGMENT_REASSEMBLER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CFR_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("reassembler check failed");

// The consequent must hold in the cycle after the antecedent.
`define CFR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("reassembler check failed");

`endif

// File: rtl/cfr_pkg.sv
`timescale 1ns / 1ps
package cfr_pkg;
	localparam int CHANNELS   = 8;
	localparam int MSG_BYTES  = 32;
	localparam int FRAG_BYTES = 16;
	localparam int CH_W       = $clog2(CHANNELS);
	localparam int DEPTH      = CHANNELS * MSG_BYTES;
	localparam int ADDR_W     = $clog2(DEPTH);

	localparam logic [1:0] OP_FRAG  = 2'd0;
	localparam logic [1:0] OP_POLL  = 2'd1;
	localparam logic [1:0] OP_RESET = 2'd2;

	localparam logic [2:0] ST_PROGRESS = 3'd0;
	localparam logic [2:0] ST_DELIVERED = 3'd1;
	localparam logic [2:0] ST_RETAINED = 3'd2;
	localparam logic [2:0] ST_BAD_ARGS = 3'd3;
	localparam logic [2:0] ST_BUSY     = 3'd4;
	localparam logic [2:0] ST_SEQ_ERR  = 3'd5;
	localparam logic [2:0] ST_CHK_ERR  = 3'd6;
	localparam logic [2:0] ST_DROPPED  = 3'd7;

	localparam logic REG_SPECIAL = 1'b0;
	localparam logic REG_SEED    = 1'b1;

	localparam logic [15:0] CRC_POLY  = 16'h1021;
	localparam logic [15:0] SEED_INIT = 16'hFFFF;

	typedef struct packed {
		logic        active;
		logic        complete;
		logic [7:0]  txn;
		logic [7:0]  next_frag;
		logic [5:0]  exp_size;
		logic [5:0]  filled;
		logic [15:0] exp_check;
		logic [15:0] run_check;
	} slot_t;

	typedef struct packed {
		logic       deliver;
		logic [2:0] ch;
		logic [2:0] st;
		logic [5:0] len;
	} cmd_t;

	function automatic slot_t clear_slot(input logic [15:0] seed);
		slot_t s;
		s = '0;
		s.run_check = seed;
		return s;
	endfunction

	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction
endpackage

// File: rtl/cfr_ram.sv
`timescale 1ns / 1ps
module cfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// File: rtl/cfr_front.sv
`timescale 1ns / 1ps
module cfr_front import cfr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [1:0]        opcode,
	input  logic [2:0]        channel,
	input  logic [7:0]        transaction,
	input  logic [7:0]        frag_seq,
	input  logic [15:0]       total_length,
	input  logic [15:0]       message_crc,
	input  logic              first_flag,
	input  logic              last_flag,
	input  logic [7:0]        frag_len,
	input  logic [7:0]        data_byte,
	input  logic              sink_ready,
	input  logic              cfg_valid,
	input  logic              cfg_index,
	input  logic [15:0]       cfg_data,
	output logic              cmd_push,
	output cmd_t              cmd,
	input  logic              cmd_full,
	input  logic              dlv_done,
	output logic              ram_we,
	output logic [ADDR_W-1:0] ram_waddr,
	output logic [7:0]        ram_wdata
);
	slot_t       slot_q [CHANNELS];
	logic [2:0]  special_q;
	logic [15:0] seed_q;
	logic [7:0]  seen_q;
	logic [2:0]  verdict_q;
	logic        dlv_busy_q;

	logic        acc;
	logic        slot_we;
	logic [CH_W-1:0] slot_ch;
	slot_t       slot_new;
	logic        frag_upd;
	logic [7:0]  seen_d;
	logic [2:0]  verdict_d;
	logic        ram_we_c;

	assign full = cmd_full | dlv_busy_q;
	assign acc  = push & ~full;

	always_comb begin
		slot_t      sl;
		logic       valid_ch;
		logic [2:0] v;
		logic [8:0] span;
		logic [CH_W-1:0] ci;
		logic [CH_W-1:0] si;
		ci        = channel[CH_W-1:0];
		si        = special_q[CH_W-1:0];
		valid_ch  = (channel != 3'd0) && (32'(channel) < CHANNELS);
		sl        = slot_q[ci];
		v         = verdict_q;
		span      = '0;
		slot_we   = 1'b0;
		slot_ch   = ci;
		slot_new  = sl;
		frag_upd  = 1'b0;
		seen_d    = seen_q;
		verdict_d = verdict_q;
		ram_we_c  = 1'b0;
		ram_waddr = ADDR_W'(ci) * ADDR_W'(MSG_BYTES) + ADDR_W'(sl.filled);
		ram_wdata = data_byte;
		cmd_push  = acc;
		cmd       = '{deliver: 1'b0, ch: channel, st: ST_BAD_ARGS, len: 6'd0};
		unique case (opcode)
			OP_POLL: begin
				cmd.ch = special_q;
				cmd.st = ST_PROGRESS;
				if (special_q != 3'd0 && 32'(special_q) < CHANNELS &&
						slot_q[si].active && slot_q[si].complete) begin
					if (sink_ready) begin
						cmd.deliver = 1'b1;
						cmd.st      = ST_DELIVERED;
						cmd.len     = slot_q[si].filled;
						slot_we     = 1'b1;
						slot_ch     = si;
						slot_new    = clear_slot(seed_q);
					end else begin
						cmd.st = ST_RETAINED;
					end
				end
			end
			OP_RESET: begin
				if (valid_ch) begin
					cmd.st   = ST_PROGRESS;
					slot_we  = 1'b1;
					slot_new = clear_slot(seed_q);
				end
			end
			OP_FRAG: begin
				frag_upd = 1'b1;
				if (seen_q == 8'd0) begin
					v = ST_PROGRESS;
					if (!valid_ch || total_length > 16'(MSG_BYTES) ||
							frag_len > 8'(FRAG_BYTES)) begin
						v = ST_BAD_ARGS;
					end else begin
						if (first_flag) begin
							if (sl.active) begin
								if (channel == special_q) begin
									v = ST_BUSY;
								end else begin
									sl = clear_slot(seed_q);
								end
							end
							if (v == ST_PROGRESS) begin
								sl.txn       = transaction;
								sl.exp_size  = total_length[5:0];
								sl.exp_check = message_crc;
								sl.run_check = seed_q;
								sl.active    = 1'b1;
							end
						end
						if (v == ST_PROGRESS) begin
							if (sl.complete) begin
								v = ST_BUSY;
							end else if (!sl.active || sl.txn != transaction ||
									sl.next_frag != frag_seq) begin
								sl = clear_slot(seed_q);
								v  = ST_SEQ_ERR;
							end else if (9'(sl.filled) + 9'(frag_len) > 9'(sl.exp_size)) begin
								sl = clear_slot(seed_q);
								v  = ST_CHK_ERR;
							end
						end
					end
				end
				if (v == ST_PROGRESS && frag_len != 8'd0) begin
					if (!valid_ch || !sl.active || sl.complete) begin
						v = ST_SEQ_ERR;
					end else if (sl.filled >= sl.exp_size || 32'(sl.filled) >= MSG_BYTES) begin
						sl = clear_slot(seed_q);
						v  = ST_CHK_ERR;
					end else begin
						ram_we_c     = 1'b1;
						ram_waddr    = ADDR_W'(ci) * ADDR_W'(MSG_BYTES) + ADDR_W'(sl.filled);
						sl.run_check = crc_byte(sl.run_check, data_byte);
						sl.filled    = sl.filled + 6'd1;
					end
				end
				span = (frag_len == 8'd0) ? 9'd1 : 9'(frag_len);
				cmd.st = v;
				if (9'(seen_q) + 9'd1 < span) begin
					seen_d    = seen_q + 8'd1;
					verdict_d = v;
				end else begin
					seen_d    = 8'd0;
					verdict_d = ST_PROGRESS;
					if (v == ST_PROGRESS && !(valid_ch && sl.active && !sl.complete)) begin
						cmd.st = ST_SEQ_ERR;
					end else if (v == ST_PROGRESS) begin
						sl.next_frag = sl.next_frag + 8'd1;
						if (last_flag) begin
							if (sl.filled != sl.exp_size || sl.run_check != sl.exp_check) begin
								sl     = clear_slot(seed_q);
								cmd.st = ST_CHK_ERR;
							end else if (sink_ready) begin
								cmd.deliver = 1'b1;
								cmd.st      = ST_DELIVERED;
								cmd.len     = sl.filled;
								sl          = clear_slot(seed_q);
							end else if (channel == special_q) begin
								sl.complete = 1'b1;
								cmd.st      = ST_RETAINED;
							end else begin
								sl     = clear_slot(seed_q);
								cmd.st = ST_DROPPED;
							end
						end
					end
				end
				slot_we  = valid_ch;
				slot_new = sl;
			end
			default: begin
				cmd.st = ST_BAD_ARGS;
			end
		endcase
	end

	assign ram_we = acc & ram_we_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				slot_q[i] <= clear_slot(SEED_INIT);
			end
			special_q  <= 3'd1;
			seed_q     <= SEED_INIT;
			seen_q     <= 8'd0;
			verdict_q  <= ST_PROGRESS;
			dlv_busy_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_SPECIAL: special_q <= cfg_data[2:0];
					REG_SEED:    seed_q    <= cfg_data;
					default:     ;
				endcase
			end
			if (acc && slot_we) begin
				slot_q[slot_ch] <= slot_new;
			end
			if (acc && frag_upd) begin
				seen_q    <= seen_d;
				verdict_q <= verdict_d;
			end
			if (acc && cmd.deliver) begin
				dlv_busy_q <= 1'b1;
			end else if (dlv_done) begin
				dlv_busy_q <= 1'b0;
			end
		end
	end
endmodule

// File: rtl/cfr_cmdq.sv
`timescale 1ns / 1ps
module cfr_cmdq import cfr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  cmd_t wdata,
	output logic full,
	input  logic rd,
	output cmd_t rdata,
	output logic empty
);
	cmd_t       entry_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] count_q;

	assign full  = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign rdata = entry_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr && !full) begin
			entry_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (wr && !full) begin
				wptr_q <= ~wptr_q;
			end
			if (rd && !empty) begin
				rptr_q <= ~rptr_q;
			end
			count_q <= count_q + 2'((wr && !full) ? 1 : 0) - 2'((rd && !empty) ? 1 : 0);
		end
	end
endmodule

// File: rtl/cfr_back.sv
`timescale 1ns / 1ps
module cfr_back import cfr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	input  logic              cmd_empty,
	output logic              cmd_pop,
	output logic              dlv_done,
	output logic              ram_re,
	output logic [ADDR_W-1:0] ram_raddr,
	input  logic [7:0]        ram_rdata,
	input  logic              pop,
	output logic              empty,
	output logic              kind,
	output logic [2:0]        out_channel,
	output logic [7:0]        out_byte,
	output logic [5:0]        message_length,
	output logic [2:0]        status,
	output logic              accepted,
	output logic              last
);
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RD   = 2'd1;
	localparam logic [1:0] S_WAIT = 2'd2;
	localparam logic [1:0] S_FIN  = 2'd3;

	logic [1:0] state_q;
	logic [5:0] idx_q;
	logic       out_v_q;
	logic       out_free;
	logic       load;
	logic       load_kind;
	logic [7:0] load_byte;
	logic [5:0] load_len;
	logic [2:0] load_st;
	logic       load_last;

	assign out_free  = ~out_v_q | pop;
	assign empty     = ~out_v_q;
	assign ram_raddr = ADDR_W'(cmd.ch) * ADDR_W'(MSG_BYTES) + ADDR_W'(idx_q);
	assign ram_re    = (state_q == S_RD);

	always_comb begin
		load      = 1'b0;
		load_kind = 1'b1;
		load_byte = 8'd0;
		load_len  = cmd.len;
		load_st   = cmd.st;
		load_last = 1'b1;
		cmd_pop   = 1'b0;
		dlv_done  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (!cmd_empty && out_free && (!cmd.deliver || cmd.len == 6'd0)) begin
					load     = 1'b1;
					cmd_pop  = 1'b1;
					dlv_done = cmd.deliver;
				end
			end
			S_WAIT: begin
				if (out_free) begin
					load      = 1'b1;
					load_kind = 1'b0;
					load_byte = ram_rdata;
					load_last = 1'b0;
				end
			end
			S_FIN: begin
				if (out_free) begin
					load     = 1'b1;
					cmd_pop  = 1'b1;
					dlv_done = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= 6'd0;
			out_v_q <= 1'b0;
		end else begin
			if (load) begin
				out_v_q <= 1'b1;
			end else if (pop) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					idx_q <= 6'd0;
					if (!cmd_empty && cmd.deliver && cmd.len != 6'd0) begin
						state_q <= S_RD;
					end
				end
				S_RD: state_q <= S_WAIT;
				S_WAIT: begin
					if (out_free) begin
						idx_q   <= idx_q + 6'd1;
						state_q <= (idx_q + 6'd1 == cmd.len) ? S_FIN : S_RD;
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind           <= load_kind;
			out_channel    <= cmd.ch;
			out_byte       <= load_byte;
			message_length <= load_len;
			status         <= load_st;
			accepted       <= (load_st <= ST_RETAINED);
			last           <= load_last;
		end
	end
endmodule

// File: rtl/channel_fragment_reassembler_core.sv
`timescale 1ns / 1ps
// Channel         Handshake            Carries
// input items     push / full          opcode, channel, header fields, data_byte, sink_ready
// result items    pop / empty          kind, out_channel, out_byte, message_length, status,
//                                      accepted, last
// configuration   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// An input item is classified and applied to the slot state in the cycle it is accepted.
// Each item that yields a single status is written into the command queue and then into the result register.
// A delivery reads the message memory one byte at a time, in states S_RD and S_WAIT, and
// waits in S_WAIT while the result register is full; input is held off (full) until its
// closing status item is loaded.
// Reset clears all slot state at once; the message memory needs no clearing.
// Full also rises when the two-entry command queue is full, which follows from result stalls.
module channel_fragment_reassembler_core import cfr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  opcode,
	input  logic [2:0]  channel,
	input  logic [7:0]  transaction,
	input  logic [7:0]  frag_seq,
	input  logic [15:0] total_length,
	input  logic [15:0] message_crc,
	input  logic        first_flag,
	input  logic        last_flag,
	input  logic [7:0]  frag_len,
	input  logic [7:0]  data_byte,
	input  logic        sink_ready,
	input  logic        pop,
	output logic        empty,
	output logic        kind,
	output logic [2:0]  out_channel,
	output logic [7:0]  out_byte,
	output logic [5:0]  message_length,
	output logic [2:0]  status,
	output logic        accepted,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);
	// Commands from the front part: one status item, or a delivery of a stored message.
	cmd_t              fq_cmd;
	cmd_t              bq_cmd;
	logic              fq_push;
	logic              fq_full;
	logic              bq_pop;
	logic              bq_empty;
	logic              dlv_done;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [7:0]        ram_wdata;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_raddr;
	logic [7:0]        ram_rdata;

	// Configuration writes are always taken; they are meant to arrive only while no item
	// is in flight.
	assign cfg_ready = 1'b1;

	cfr_front u_front (
		.clk, .arst_n, .push, .full, .opcode, .channel, .transaction, .frag_seq,
		.total_length, .message_crc, .first_flag, .last_flag, .frag_len, .data_byte,
		.sink_ready, .cfg_valid, .cfg_index, .cfg_data,
		.cmd_push(fq_push), .cmd(fq_cmd), .cmd_full(fq_full), .dlv_done,
		.ram_we, .ram_waddr, .ram_wdata
	);

	cfr_cmdq u_cmdq (
		.clk, .arst_n, .wr(fq_push), .wdata(fq_cmd), .full(fq_full),
		.rd(bq_pop), .rdata(bq_cmd), .empty(bq_empty)
	);

	// Message bytes, one row of MSG_BYTES per channel.
	cfr_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_store (
		.clk, .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.re(ram_re), .raddr(ram_raddr), .rdata(ram_rdata)
	);

	cfr_back u_back (
		.clk, .arst_n, .cmd(bq_cmd), .cmd_empty(bq_empty), .cmd_pop(bq_pop), .dlv_done,
		.ram_re, .ram_raddr, .ram_rdata, .pop, .empty, .kind, .out_channel, .out_byte,
		.message_length, .status, .accepted, .last
	);
endmodule

// File: rtl/cfr_checker.sv
`timescale 1ns / 1ps
`include "channel_fragment_reassembler_core_macros.svh"
module cfr_checker import cfr_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       pop,
	input logic       empty,
	input logic       kind,
	input logic [7:0] out_byte,
	input logic [5:0] message_length,
	input logic [2:0] status,
	input logic       accepted,
	input logic       last
);
	// A message byte always belongs to a delivery that is still running.
	`CFR_ASSERT_NOW(a_byte_item, !empty && !kind, status == ST_DELIVERED && !last && |message_length)
	// Accepted follows from the status code.
	`CFR_ASSERT_NOW(a_accepted, !empty, accepted == (status <= ST_RETAINED))
	// A waiting result is held until it is taken.
	`CFR_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(out_byte) && $stable(status))
endmodule

bind channel_fragment_reassembler_core cfr_checker u_checker (
	.clk, .arst_n, .pop, .empty, .kind, .out_byte, .message_length, .status, .accepted, .last
);

// File: dv/tb.sv
`timescale 1ns / 1ps
module tb;
	import cfr_pkg::*;

	// Cycle limit for the whole run. Even with deliveries, random result stalls, sender gaps
	// and the long hold-off the run stays far below the limit.
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_ITEMS = 290;
	// The opcode that the block does not use.
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// One result item as seen on the output side.
	typedef struct packed {
		logic       kind;
		logic [2:0] ch;
		logic [7:0] byte_val;
		logic [5:0] len;
		logic [2:0] st;
		logic       acc;
		logic       lst;
	} result_t;

	// One input item.
	typedef struct packed {
		logic [1:0]  op;
		logic [2:0]  ch;
		logic [7:0]  txn;
		logic [7:0]  idx;
		logic [15:0] tot;
		logic [15:0] mcrc;
		logic        first;
		logic        lastf;
		logic [7:0]  dl;
		logic [7:0]  db;
		logic        ready;
	} frag_item_t;

	int mismatch_count = 0;

	// Reports one mismatch on a line of its own and counts it.
	task automatic report_mismatch(input string what);
		mismatch_count++;
		$display("[%0t] MISMATCH: %s", $realtime, what);
	endtask

	// The scoreboard keeps its own copy of every slot and of the configuration. Each accepted
	// input item is run through the same reassembly rules and the result items it should
	// cause are queued; each result popped from the block is compared with the oldest one.
	class reassembly_scoreboard;
		logic        sl_active [CHANNELS];
		logic        sl_complete [CHANNELS];
		logic [7:0]  sl_txn [CHANNELS];
		logic [7:0]  sl_next [CHANNELS];
		logic [5:0]  sl_exp_size [CHANNELS];
		logic [5:0]  sl_filled [CHANNELS];
		logic [15:0] sl_exp_crc [CHANNELS];
		logic [15:0] sl_run_crc [CHANNELS];
		logic [7:0]  msg_bytes [CHANNELS * MSG_BYTES];
		int          seen_in_frag;
		logic [2:0]  verdict;
		logic [2:0]  special_ch;
		logic [15:0] seed;
		result_t     pending_results[$];
		int          checked;
		int          delivered_msgs;

		function new();
			special_ch = 3'd1;
			seed = SEED_INIT;
			for (int c = 0; c < CHANNELS; c++)
				wipe(c);
			seen_in_frag = 0;
			verdict = ST_PROGRESS;
			checked = 0;
			delivered_msgs = 0;
		endfunction

		function void wipe(input int c);
			sl_active[c] = 0;
			sl_complete[c] = 0;
			sl_txn[c] = '0;
			sl_next[c] = '0;
			sl_exp_size[c] = '0;
			sl_filled[c] = '0;
			sl_exp_crc[c] = '0;
			sl_run_crc[c] = seed;
		endfunction

		function void set_register(input logic idx, input logic [15:0] val);
			if (idx == REG_SPECIAL)
				special_ch = val[2:0];
			else
				seed = val;
		endfunction

		// CRC-16/CCITT, MSB first, one byte.
		function logic [15:0] ccitt_step(input logic [15:0] crc, input logic [7:0] b);
			logic [15:0] c;
			c = crc ^ {b, 8'h00};
			for (int i = 0; i < 8; i++)
				c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
			return c;
		endfunction

		function void add(input logic kind, input logic [2:0] ch, input logic [7:0] b,
				input logic [5:0] len, input logic [2:0] st, input logic lst);
			result_t r;
			r.kind = kind;
			r.ch = ch;
			r.byte_val = b;
			r.len = len;
			r.st = st;
			r.acc = (st <= ST_RETAINED);
			r.lst = lst;
			pending_results.push_back(r);
		endfunction

		function void status_only(input logic [2:0] ch, input logic [2:0] st);
			add(1'b1, ch, 8'h00, 6'd0, st, 1'b1);
		endfunction

		function void deliver_message(input int c);
			int n;
			n = sl_filled[c];
			for (int i = 0; i < n; i++)
				add(1'b0, c[2:0], msg_bytes[c * MSG_BYTES + i], n[5:0], ST_DELIVERED, 1'b0);
			add(1'b1, c[2:0], 8'h00, n[5:0], ST_DELIVERED, 1'b1);
			wipe(c);
			delivered_msgs++;
		endfunction

		// Notes an accepted input item and predicts its results.
		function void note_item(input frag_item_t it);
			bit valid_ch;
			int c;
			int span;
			logic [2:0] st;
			valid_ch = (it.ch != 0) && (it.ch < CHANNELS);
			c = it.ch;
			if (it.op == OP_POLL) begin
				if (special_ch != 0 && sl_active[special_ch] && sl_complete[special_ch]) begin
					if (it.ready)
						deliver_message(special_ch);
					else
						status_only(special_ch, ST_RETAINED);
				end else begin
					status_only(special_ch, ST_PROGRESS);
				end
				return;
			end
			if (it.op == OP_RESET) begin
				if (valid_ch) begin
					wipe(c);
					status_only(it.ch, ST_PROGRESS);
				end else begin
					status_only(it.ch, ST_BAD_ARGS);
				end
				return;
			end
			if (it.op != OP_FRAG) begin
				status_only(it.ch, ST_BAD_ARGS);
				return;
			end
			// The first item of a fragment carries the header checks.
			if (seen_in_frag == 0) begin
				verdict = ST_PROGRESS;
				if (!valid_ch || it.tot > MSG_BYTES || it.dl > FRAG_BYTES) begin
					verdict = ST_BAD_ARGS;
				end else begin
					if (it.first) begin
						if (sl_active[c]) begin
							if (it.ch == special_ch)
								verdict = ST_BUSY;
							else
								wipe(c);
						end
						if (verdict == ST_PROGRESS) begin
							sl_txn[c] = it.txn;
							sl_exp_size[c] = it.tot[5:0];
							sl_exp_crc[c] = it.mcrc;
							sl_run_crc[c] = seed;
							sl_active[c] = 1;
						end
					end
					if (verdict == ST_PROGRESS) begin
						if (sl_complete[c]) begin
							verdict = ST_BUSY;
						end else if (!sl_active[c] || sl_txn[c] != it.txn
								|| sl_next[c] != it.idx) begin
							wipe(c);
							verdict = ST_SEQ_ERR;
						end else if (int'(sl_filled[c]) + int'(it.dl) > int'(sl_exp_size[c])) begin
							wipe(c);
							verdict = ST_CHK_ERR;
						end
					end
				end
			end
			if (verdict == ST_PROGRESS && it.dl != 0) begin
				if (!valid_ch || !sl_active[c] || sl_complete[c]) begin
					verdict = ST_SEQ_ERR;
				end else if (sl_filled[c] >= sl_exp_size[c] || sl_filled[c] >= MSG_BYTES) begin
					wipe(c);
					verdict = ST_CHK_ERR;
				end else begin
					msg_bytes[c * MSG_BYTES + sl_filled[c]] = it.db;
					sl_run_crc[c] = ccitt_step(sl_run_crc[c], it.db);
					sl_filled[c]++;
				end
			end
			span = (it.dl == 0) ? 1 : it.dl;
			if (seen_in_frag + 1 < span) begin
				seen_in_frag = (seen_in_frag + 1) & 8'hFF;
				status_only(it.ch, verdict);
				return;
			end
			seen_in_frag = 0;
			st = verdict;
			verdict = ST_PROGRESS;
			if (st == ST_PROGRESS && !(valid_ch && sl_active[c] && !sl_complete[c]))
				st = ST_SEQ_ERR;
			if (st != ST_PROGRESS) begin
				status_only(it.ch, st);
				return;
			end
			sl_next[c]++;
			if (!it.lastf) begin
				status_only(it.ch, ST_PROGRESS);
				return;
			end
			if (sl_filled[c] != sl_exp_size[c] || sl_run_crc[c] != sl_exp_crc[c]) begin
				wipe(c);
				status_only(it.ch, ST_CHK_ERR);
				return;
			end
			sl_complete[c] = 1;
			if (it.ready) begin
				deliver_message(c);
			end else if (it.ch == special_ch) begin
				status_only(it.ch, ST_RETAINED);
			end else begin
				wipe(c);
				status_only(it.ch, ST_DROPPED);
			end
		endfunction

		// Checks one popped result against the oldest expectation.
		task check_result(input result_t got);
			result_t want;
			checked++;
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result %p", got));
				return;
			end
			want = pending_results.pop_front();
			if (got.kind !== want.kind)
				report_mismatch($sformatf("kind %0d, wanted %0d", got.kind, want.kind));
			if (got.ch !== want.ch)
				report_mismatch($sformatf("out_channel %0d, wanted %0d", got.ch, want.ch));
			if (got.byte_val !== want.byte_val)
				report_mismatch($sformatf("out_byte %0h, wanted %0h", got.byte_val,
					want.byte_val));
			if (got.len !== want.len)
				report_mismatch($sformatf("message_length %0d, wanted %0d", got.len, want.len));
			if (got.st !== want.st)
				report_mismatch($sformatf("status %0d, wanted %0d", got.st, want.st));
			if (got.acc !== want.acc)
				report_mismatch($sformatf("accepted %0d, wanted %0d", got.acc, want.acc));
			if (got.lst !== want.lst)
				report_mismatch($sformatf("last %0d, wanted %0d", got.lst, want.lst));
		endtask
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        push = 0;
	logic        full;
	logic [1:0]  opcode = OP_FRAG;
	logic [2:0]  channel = '0;
	logic [7:0]  transaction = '0;
	logic [7:0]  frag_seq = '0;
	logic [15:0] total_length = '0;
	logic [15:0] message_crc = '0;
	logic        first_flag = 0;
	logic        last_flag = 0;
	logic [7:0]  frag_len = '0;
	logic [7:0]  data_byte = '0;
	logic        sink_ready = 0;
	logic        pop = 0;
	logic        empty;
	logic        kind;
	logic [2:0]  out_channel;
	logic [7:0]  out_byte;
	logic [5:0]  message_length;
	logic [2:0]  status;
	logic        accepted;
	logic        last;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic        cfg_index = REG_SPECIAL;
	logic [15:0] cfg_data = '0;

	channel_fragment_reassembler_core DUT (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	reassembly_scoreboard board = new();

	// Idling control. While calm is set neither side idles; hold_off stops the receiver.
	bit calm = 0;
	bit hold_off = 0;
	int sent_items = 0;
	int cycle_count = 0;

	// The sender drives one item and waits until the block has taken it. Gaps are drawn
	// before each item, so that they land at every stage of a fragment and a delivery.
	task automatic send_item(input frag_item_t it);
		while (!calm && $urandom_range(99) < 19) begin
			@(posedge clk);
			push <= 0;
		end
		@(posedge clk);
		push <= 1;
		opcode <= it.op;
		channel <= it.ch;
		transaction <= it.txn;
		frag_seq <= it.idx;
		total_length <= it.tot;
		message_crc <= it.mcrc;
		first_flag <= it.first;
		last_flag <= it.lastf;
		frag_len <= it.dl;
		data_byte <= it.db;
		sink_ready <= it.ready;
		do
			@(posedge clk);
		while (full);
		// The item was taken at this edge; the block sees it in the same step as the
		// scoreboard notes it, so prediction follows the order of acceptance.
		board.note_item(it);
		sent_items++;
		push <= 0;
	endtask

	// Waits for every expected result, then a few more cycles so that no item without a
	// result is still in the pipeline, before a register write.
	task automatic drain();
		while (board.pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_register(input logic idx, input logic [15:0] val);
		drain();
		@(posedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		board.set_register(idx, val);
		cfg_valid <= 0;
	endtask

	// Receiver: pops at random, or always while calm is set, except during the hold-off.
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty)
				board.check_result({kind, out_channel, out_byte, message_length, status,
					accepted, last});
			pop <= !hold_off && (calm || $urandom_range(99) >= 19);
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// A fragment item with neutral header fields.
	function automatic frag_item_t blank_item();
		frag_item_t it;
		it = '0;
		it.op = OP_FRAG;
		return it;
	endfunction

	// Builds the CRC that a message will carry under the current seed.
	function automatic logic [15:0] message_check(input logic [7:0] msg[$]);
		logic [15:0] c;
		c = board.seed;
		foreach (msg[i])
			c = board.ccitt_step(c, msg[i]);
		return c;
	endfunction

	// Sends a whole message on one channel, split into fragments of at most frag_max bytes.
	// With spoil set, one header field or byte may be damaged somewhere along the way.
	task automatic send_message(input logic [2:0] ch, input int len, input int frag_max,
			input bit ready, input bit spoil);
		logic [7:0] msg[$];
		logic [7:0] txn;
		logic [15:0] crc;
		frag_item_t it;
		int pos;
		int frag;
		int n;
		int bad_at;
		for (int i = 0; i < len; i++)
			msg.push_back(8'($urandom_range(255)));
		txn = 8'($urandom_range(255));
		crc = message_check(msg);
		bad_at = spoil ? int'($urandom_range(len)) : -1;
		pos = 0;
		frag = 0;
		do begin
			n = $urandom_range(frag_max < 1 ? 1 : frag_max, 1);
			if (n > len - pos)
				n = len - pos;
			for (int k = 0; k < (n == 0 ? 1 : n); k++) begin
				it = blank_item();
				it.ch = ch;
				it.txn = txn;
				it.idx = 8'(frag);
				it.tot = 16'(len);
				it.mcrc = crc;
				it.first = (frag == 0);
				it.lastf = (pos + n == len);
				it.dl = 8'(n);
				it.db = (n == 0) ? 8'($urandom_range(255)) : msg[pos + k];
				it.ready = ready;
				if (pos + k == bad_at) begin
					case ($urandom_range(3))
						0: it.db = ~it.db;
						1: it.txn = ~txn;
						2: it.idx = 8'(frag + 1);
						default: it.mcrc = ~crc;
					endcase
				end
				send_item(it);
			end
			pos += n;
			frag++;
		end while (pos < len);
	endtask

	// A fully random item, the noise part of the stimulus.
	function automatic frag_item_t noise_item();
		frag_item_t it;
		it.op = 2'($urandom_range(3));
		it.ch = 3'($urandom_range(7));
		it.txn = 8'($urandom_range(255));
		it.idx = $urandom_range(3) == 0 ? 8'($urandom_range(255)) : 8'($urandom_range(2));
		it.tot = $urandom_range(3) == 0 ? 16'($urandom_range(65535)) : 16'($urandom_range(40));
		it.mcrc = 16'($urandom_range(65535));
		it.first = 1'($urandom_range(1));
		it.lastf = 1'($urandom_range(1));
		// Only one item per noise fragment, so lengths stay mostly at 0 or 1.
		it.dl = $urandom_range(7) == 0 ? 8'($urandom_range(255)) : 8'($urandom_range(1));
		it.db = 8'($urandom_range(255));
		it.ready = 1'($urandom_range(1));
		return it;
	endfunction

	function automatic frag_item_t control_item(input logic [1:0] op, input logic [2:0] ch,
			input bit ready);
		frag_item_t it;
		it = blank_item();
		it.op = op;
		it.ch = ch;
		it.ready = ready;
		return it;
	endfunction

	initial begin
		frag_item_t it;
		int start_items;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed part: the extremes of every field and each special case.
		calm = 1;
		send_message(3'd2, 0, 1, 1, 0);            // empty message, delivered at once
		send_message(3'd3, 32, 16, 1, 0);          // longest message, widest fragments
		send_message(3'd1, 5, 4, 0, 0);            // retained on the special channel
		send_item(control_item(OP_POLL, 3'd0, 0)); // poll with the sink still busy
		send_message(3'd1, 3, 3, 1, 0);            // retained slot refuses a new FIRST
		send_item(control_item(OP_POLL, 3'd0, 1)); // poll delivers the retained message
		send_item(control_item(OP_POLL, 3'd0, 1)); // nothing left to deliver
		send_message(3'd4, 6, 6, 0, 0);            // dropped: not the special channel
		send_message(3'd5, 4, 2, 1, 1);            // damaged message
		send_item(control_item(OP_RESET, 3'd0, 0));// reset of the invalid channel
		send_item(control_item(OP_RESET, 3'd7, 0));
		send_item(control_item(OP_UNUSED, 3'd7, 0));
		it = blank_item();
		it.ch = 3'd0;                              // invalid channel
		it.tot = 16'hFFFF;
		it.dl = 8'hFF;
		it.mcrc = 16'hFFFF;
		it.txn = 8'hFF;
		it.idx = 8'hFF;
		it.db = 8'hFF;
		it.first = 1;
		it.lastf = 1;
		it.ready = 1;
		send_item(it);
		it = blank_item();
		it.ch = 3'd6;                              // a byte to an inactive slot
		it.dl = 1;
		send_item(it);
		drain();

		// Long hold-off: the receiver stops while the sender keeps offering items.
		hold_off = 1;
		fork
			send_message(3'd6, 20, 8, 1, 0);
			begin
				repeat (300) @(posedge clk);
				hold_off = 0;
			end
		join
		calm = 0;

		// Random part, in phases between register settings, extremes among them.
		start_items = sent_items;
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					write_register(REG_SPECIAL, 16'd7);
					write_register(REG_SEED, 16'h0000);
				end
				1: begin
					write_register(REG_SPECIAL, 16'($urandom_range(6, 2)));
					write_register(REG_SEED, 16'($urandom_range(65535)));
				end
				2: begin
					write_register(REG_SPECIAL, 16'd1);
					write_register(REG_SEED, 16'hFFFF);
				end
				default: begin
					write_register(REG_SPECIAL, 16'($urandom_range(7, 1)));
					write_register(REG_SEED, 16'($urandom_range(65535)));
				end
			endcase
			calm = (phase == 2);
			while (sent_items - start_items < (phase + 1) * RANDOM_ITEMS / 4) begin
				case ($urandom_range(9))
					0, 1: send_item(noise_item());
					2: send_item(control_item(2'($urandom_range(2, 1)), 3'($urandom_range(7)),
						1'($urandom_range(1))));
					default: send_message(3'($urandom_range(7, 1)),
						$urandom_range(15) == 0 ? 32 : $urandom_range(8),
						$urandom_range(15) == 0 ? 16 : $urandom_range(4, 1),
						$urandom_range(3) != 0, $urandom_range(4) == 0);
				endcase
			end
			calm = 0;
		end

		drain();
		repeat (80) @(posedge clk);
		$display("Sent %0d items, checked %0d results, %0d messages delivered.",
			sent_items, board.checked, board.delivered_msgs);
		$display("Covered directed cases, a long result stall and four register settings.");
		if (mismatch_count == 0 && board.pending_results.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			if (board.pending_results.size() != 0)
				report_mismatch($sformatf("%0d results never arrived",
					board.pending_results.size()));
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule
